FILE: rtl/dvnad_pkg.sv
// Shared types, constants and microcode program for the date check / add-days block.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dvnad_pkg;

    // Field widths and limits
    localparam int YEAR_MAX   = 16383;
    localparam int ADD_BITS   = 16;
    localparam int DAY_W      = 5;
    localparam int MON_W      = 4;
    localparam int YEAR_W     = 14;
    localparam int DN_W       = 23;
    localparam int ERR_W      = 2;
    localparam int FIRST_YEAR = 1601;

    // Walked year must hold YEAR_MAX + 1 and any 14-bit input year
    localparam int NY_CLOG = $clog2(YEAR_MAX + 2);
    localparam int NY_W    = (NY_CLOG > YEAR_W) ? NY_CLOG : YEAR_W;
    // Remaining days: day of year (<= 366) plus the add count
    localparam int REM_W   = ADD_BITS + 2;
    localparam int DOY_W   = 9;
    localparam int C100_W  = 7;
    localparam int C400_W  = 9;

    // x / 100 as (x * 5243) >> 19, exact for x < 2**14
    localparam int RECIP_100   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int Q_W         = 8;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_YEAR  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MONTH = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DAY   = 2'd3;

    // Program addresses
    typedef logic [3:0] step_t;
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_DIVY   = 4'd1;
    localparam step_t STEP_MODY   = 4'd2;
    localparam step_t STEP_CHECK  = 4'd3;
    localparam step_t STEP_DIVD   = 4'd4;
    localparam step_t STEP_DAYNUM = 4'd5;
    localparam step_t STEP_YEAR   = 4'd6;
    localparam step_t STEP_MONTH  = 4'd7;
    localparam step_t STEP_DONE   = 4'd8;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DIVY,
        OP_MODY,
        OP_CHECK,
        OP_DIVD,
        OP_DAYNUM,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        CND_NONE,
        CND_START,
        CND_ERR,
        CND_YDONE,
        CND_MDONE,
        CND_OUTFREE
    } cond_t;

    // One control word: datapath op, jump condition, hold-on-false, jump target
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  stay;
        step_t target;
    } ucode_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic err;
        logic ydone;
        logic mdone;
        logic out_free;
    } flags_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        begin
            unique case (s)
                STEP_IDLE:   w = '{OP_IDLE,   CND_START,   1'b1, STEP_DIVY};
                STEP_DIVY:   w = '{OP_DIVY,   CND_NONE,    1'b0, STEP_IDLE};
                STEP_MODY:   w = '{OP_MODY,   CND_NONE,    1'b0, STEP_IDLE};
                STEP_CHECK:  w = '{OP_CHECK,  CND_ERR,     1'b0, STEP_DONE};
                STEP_DIVD:   w = '{OP_DIVD,   CND_NONE,    1'b0, STEP_IDLE};
                STEP_DAYNUM: w = '{OP_DAYNUM, CND_NONE,    1'b0, STEP_IDLE};
                STEP_YEAR:   w = '{OP_YEAR,   CND_YDONE,   1'b1, STEP_MONTH};
                STEP_MONTH:  w = '{OP_MONTH,  CND_MDONE,   1'b1, STEP_DONE};
                STEP_DONE:   w = '{OP_DONE,   CND_OUTFREE, 1'b1, STEP_IDLE};
                default:     w = '{OP_IDLE,   CND_NONE,    1'b0, STEP_IDLE};
            endcase
            return w;
        end
    endfunction

    function automatic logic is_leap(input logic [1:0] low2,
                                     input logic [C100_W-1:0] c100,
                                     input logic [C400_W-1:0] c400);
        return (low2 == 2'd0) && ((c100 != '0) || (c400 == '0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] r;
        begin
            case (m)
                4'd2:                      r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7,
                4'd8, 4'd10, 4'd12:        r = 5'd31;
                default:                   r = 5'd0;
            endcase
            return r;
        end
    endfunction

    // Days before the first of month m
    function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                     input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] r;
        logic [DOY_W-1:0] adj;
        begin
            adj = (leap && (m > 4'd2)) ? 9'd1 : 9'd0;
            case (m)
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r + adj;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dvnad_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on dvnad_pkg (ucode_t, flags_t, ucode_rom).
`timescale 1ns / 1ps
`default_nettype none

module dvnad_useq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dvnad_pkg::flags_t flags,
    output dvnad_pkg::ucode_t      uop
);
    import dvnad_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    logic  cond_hit;

    assign uop = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (uop.cond)
            CND_NONE:    cond_hit = 1'b0;
            CND_START:   cond_hit = flags.start;
            CND_ERR:     cond_hit = flags.err;
            CND_YDONE:   cond_hit = flags.ydone;
            CND_MDONE:   cond_hit = flags.mdone;
            CND_OUTFREE: cond_hit = flags.out_free;
            default:     cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit)
        begin
            pc_next = uop.target;
        end
        else if (uop.stay)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/date_validate_number_add_days.sv
// Top level: Gregorian date check, day number and add-days walk.
// Depends on dvnad_pkg and dvnad_useq (microcode sequencer).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: date_day, date_month,
//   date_year and days_to_add. Output channel (out_valid/out_ready) carries one
//   result item per input item: date_ok, error_code, day_number, the shifted
//   date new_day/new_month/new_year and year_overflow.
//   A small microcode program steps a plain datapath: two constant
//   multiplies give year/100 for the leap test, one step checks the date,
//   two more form the day number, then the year walk subtracts one whole year
//   per cycle and the month walk one month per cycle.
//   An invalid date jumps from the check step straight to the final step.
//   The year loop sets the rate: one item is in work at a time, the next is
//   taken once the program is back at its idle step.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the program holds at its final step
//   until the register frees up.
//   Reset returns the program to idle and drops out_valid; no pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module date_validate_number_add_days (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [dvnad_pkg::DAY_W-1:0]      date_day,
    input  wire logic [dvnad_pkg::MON_W-1:0]      date_month,
    input  wire logic [dvnad_pkg::YEAR_W-1:0]     date_year,
    input  wire logic [dvnad_pkg::ADD_BITS-1:0]   days_to_add,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  date_ok,
    output logic [dvnad_pkg::ERR_W-1:0]           error_code,
    output logic [dvnad_pkg::DN_W-1:0]            day_number,
    output logic [dvnad_pkg::DAY_W-1:0]           new_day,
    output logic [dvnad_pkg::MON_W-1:0]           new_month,
    output logic [dvnad_pkg::YEAR_W-1:0]          new_year,
    output logic                                  year_overflow
);
    import dvnad_pkg::*;

    ucode_t uop;
    flags_t flags;

    // Item registers
    logic [DAY_W-1:0]    day_reg,   day_next;
    logic [MON_W-1:0]    month_reg, month_next;
    logic [YEAR_W-1:0]   year_reg,  year_next;
    logic [ADD_BITS-1:0] add_reg,   add_next;

    // Working registers
    logic [Q_W-1:0]      q_reg,      q_next;
    logic [C100_W-1:0]   c100_reg,   c100_next;   // ny mod 100
    logic [C400_W-1:0]   c400_reg,   c400_next;   // ny mod 400
    logic [ERR_W-1:0]    err_reg,    err_next;
    logic [DOY_W-1:0]    doy_reg,    doy_next;
    logic [REM_W-1:0]    rem_reg,    rem_next;
    logic [NY_W-1:0]     ny_reg,     ny_next;
    logic [MON_W-1:0]    nm_reg,     nm_next;
    logic                over_reg,   over_next;
    logic [DN_W-1:0]     dn_reg,     dn_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic                ok_reg,     ok_next;
    logic [ERR_W-1:0]    oerr_reg,   oerr_next;
    logic [DN_W-1:0]     odn_reg,    odn_next;
    logic [DAY_W-1:0]    oday_reg,   oday_next;
    logic [MON_W-1:0]    omon_reg,   omon_next;
    logic [YEAR_W-1:0]   oyear_reg,  oyear_next;
    logic                oovf_reg,   oovf_next;

    // Combinational helpers
    logic                accept;
    logic                out_free;
    logic                leap_cur;
    logic [PROD_W-1:0]   prod;
    logic [YEAR_W-1:0]   diff;
    logic [YEAR_W-1:0]   mod100;
    logic [DAY_W-1:0]    lim;
    logic [REM_W-1:0]    ylen;
    logic [REM_W-1:0]    mlen;
    logic                ydone;
    logic                mdone;
    logic [DN_W-1:0]     full;

    dvnad_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uop   (uop)
    );

    assign in_ready = (uop.op == OP_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Leap test of the year currently held in ny_reg (same as year_reg until walked)
    assign leap_cur = is_leap(ny_reg[1:0], c100_reg, c400_reg);
    assign diff     = year_reg - YEAR_W'(FIRST_YEAR);
    assign mod100   = year_reg - YEAR_W'(q_reg) * YEAR_W'(100);
    assign lim      = month_len(leap_cur, month_reg);
    assign ylen     = leap_cur ? REM_W'(366) : REM_W'(365);
    assign mlen     = REM_W'(month_len(leap_cur, nm_reg));
    assign ydone    = over_reg || (rem_reg < ylen);
    assign mdone    = over_reg || (nm_reg == MON_W'(12)) || (rem_reg < mlen);
    assign full     = DN_W'(diff) * DN_W'(365) + DN_W'(diff >> 2)
                      - DN_W'(q_reg) + DN_W'(q_reg >> 2);

    always_comb
    begin
        if (year_reg < YEAR_W'(FIRST_YEAR))
        begin
            err_next = ERR_YEAR;
        end
        else if ((month_reg == '0) || (month_reg > MON_W'(12)))
        begin
            err_next = ERR_MONTH;
        end
        else if ((day_reg == '0) || (day_reg > lim))
        begin
            err_next = ERR_DAY;
        end
        else
        begin
            err_next = ERR_OK;
        end
    end

    always_comb
    begin
        flags.start    = in_valid;
        flags.err      = (err_next != ERR_OK);
        flags.ydone    = ydone;
        flags.mdone    = mdone;
        flags.out_free = out_free;
    end

    // Datapath: one op per control word
    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        add_next   = add_reg;
        q_next     = q_reg;
        c100_next  = c100_reg;
        c400_next  = c400_reg;
        doy_next   = doy_reg;
        rem_next   = rem_reg;
        ny_next    = ny_reg;
        nm_next    = nm_reg;
        over_next  = over_reg;
        dn_next    = dn_reg;
        prod       = '0;

        unique case (uop.op)
            OP_IDLE:
            begin
                if (accept)
                begin
                    day_next   = date_day;
                    month_next = date_month;
                    year_next  = date_year;
                    add_next   = days_to_add;
                    ny_next    = NY_W'(date_year);
                    nm_next    = MON_W'(1);
                end
            end
            OP_DIVY:
            begin
                prod   = PROD_W'(year_reg) * PROD_W'(RECIP_100);
                q_next = Q_W'(prod >> RECIP_SHIFT);
            end
            OP_MODY:
            begin
                c100_next = C100_W'(mod100);
                c400_next = C400_W'(mod100) + C400_W'(q_reg[1:0]) * C400_W'(100);
            end
            OP_CHECK:
            begin
                doy_next = month_start(leap_cur, month_reg) + DOY_W'(day_reg);
                rem_next = REM_W'(doy_next) - REM_W'(1) + REM_W'(add_reg);
            end
            OP_DIVD:
            begin
                prod   = PROD_W'(diff) * PROD_W'(RECIP_100);
                q_next = Q_W'(prod >> RECIP_SHIFT);
            end
            OP_DAYNUM:
            begin
                dn_next   = full + DN_W'(doy_reg);
                over_next = (ny_reg > NY_W'(YEAR_MAX));
            end
            OP_YEAR:
            begin
                if (!ydone)
                begin
                    rem_next  = rem_reg - ylen;
                    ny_next   = ny_reg + NY_W'(1);
                    c100_next = (c100_reg == C100_W'(99)) ? '0 : c100_reg + C100_W'(1);
                    c400_next = (c400_reg == C400_W'(399)) ? '0 : c400_reg + C400_W'(1);
                    over_next = (ny_next > NY_W'(YEAR_MAX));
                end
            end
            OP_MONTH:
            begin
                if (!mdone)
                begin
                    rem_next = rem_reg - mlen;
                    nm_next  = nm_reg + MON_W'(1);
                end
            end
            OP_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register load
    always_comb
    begin
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        ok_next        = ok_reg;
        oerr_next      = oerr_reg;
        odn_next       = odn_reg;
        oday_next      = oday_reg;
        omon_next      = omon_reg;
        oyear_next     = oyear_reg;
        oovf_next      = oovf_reg;
        if ((uop.op == OP_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            oerr_next      = err_reg;
            if (err_reg != ERR_OK)
            begin
                ok_next    = 1'b0;
                odn_next   = '0;
                oday_next  = '0;
                omon_next  = '0;
                oyear_next = '0;
                oovf_next  = 1'b0;
            end
            else if (over_reg)
            begin
                // saturate past the last year
                ok_next    = 1'b1;
                odn_next   = dn_reg;
                oday_next  = DAY_W'(31);
                omon_next  = MON_W'(12);
                oyear_next = YEAR_W'(YEAR_MAX);
                oovf_next  = 1'b1;
            end
            else
            begin
                ok_next    = 1'b1;
                odn_next   = dn_reg;
                oday_next  = DAY_W'(rem_reg + REM_W'(1));
                omon_next  = nm_reg;
                oyear_next = YEAR_W'(ny_reg);
                oovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        add_reg   <= add_next;
        q_reg     <= q_next;
        c100_reg  <= c100_next;
        c400_reg  <= c400_next;
        doy_reg   <= doy_next;
        rem_reg   <= rem_next;
        ny_reg    <= ny_next;
        nm_reg    <= nm_next;
        over_reg  <= over_next;
        dn_reg    <= dn_next;
        ok_reg    <= ok_next;
        oerr_reg  <= oerr_next;
        odn_reg   <= odn_next;
        oday_reg  <= oday_next;
        omon_reg  <= omon_next;
        oyear_reg <= oyear_next;
        oovf_reg  <= oovf_next;
        if (uop.op == OP_CHECK)
        begin
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign date_ok       = ok_reg;
    assign error_code    = oerr_reg;
    assign day_number    = odn_reg;
    assign new_day       = oday_reg;
    assign new_month     = omon_reg;
    assign new_year      = oyear_reg;
    assign year_overflow = oovf_reg;

    // Checks
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_ok |-> error_code == ERR_OK)
        else $error("valid date with nonzero error code");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !date_ok |-> day_number == '0 && new_year == '0 && !year_overflow)
        else $error("invalid date with nonzero result");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && year_overflow |-> new_month == MON_W'(12) && new_day == DAY_W'(31))
        else $error("overflow result not saturated");

    a_month_rng: assert property (@(posedge clk) disable iff (!rst_n)
        uop.op == OP_MONTH |-> nm_reg != '0 && nm_reg <= MON_W'(12))
        else $error("month walk out of range");

    a_rise_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(uop.op == OP_DONE))
        else $error("result appeared outside final step");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the date check / day number / add-days block.
// Depends on rtl/dvnad_pkg.sv and rtl/date_validate_number_add_days.sv; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import dvnad_pkg::*;

    // No accepted item on either channel for this many cycles means a hang.
    // Slowest legal gap: a long receiver hold plus one full date walk.
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;
    // Longest walk is about 180 years plus 11 months plus fixed steps
    localparam int DRAIN_CYCLES = 250;
    localparam int RAND_PER_PHASE = 330;

    // One result item, field for field
    typedef struct packed {
        logic                ok;
        logic [ERR_W-1:0]    err;
        logic [DN_W-1:0]     dnum;
        logic [DAY_W-1:0]    nday;
        logic [MON_W-1:0]    nmon;
        logic [YEAR_W-1:0]   nyear;
        logic                ovf;
    } date_res_t;

    // Holds the predicted results of accepted items, oldest first
    class date_scoreboard;
        date_res_t   pending_q[$];
        int unsigned errors = 0;

        static function bit leap(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int unsigned month_days(int unsigned y, int unsigned m);
            case (m)
                2:           return leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        // Date check, day number and forward shift
        static function date_res_t calc_date(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                             logic [YEAR_W-1:0] y,
                                             logic [ADD_BITS-1:0] add);
            date_res_t   r;
            int unsigned diff, doy, rem, ny, nm;
            bit          over;
            r = '0;
            if (y < FIRST_YEAR)
                r.err = ERR_YEAR;
            else if (m < 1 || m > 12)
                r.err = ERR_MONTH;
            else if (d < 1 || d > month_days(y, m))
                r.err = ERR_DAY;
            if (r.err != ERR_OK)
                return r;

            r.ok = 1'b1;
            diff = y - FIRST_YEAR;
            doy  = d;
            for (int unsigned k = 1; k < m; k++)
                doy += month_days(y, k);
            r.dnum = DN_W'(diff * 365 + diff / 4 - diff / 100 + diff / 400 + doy);

            rem  = doy - 1 + add;
            ny   = y;
            over = (ny > YEAR_MAX);
            while (!over && rem >= (leap(ny) ? 366 : 365)) begin
                rem -= leap(ny) ? 366 : 365;
                ny++;
                over = (ny > YEAR_MAX);
            end
            if (over) begin
                r.nday  = 5'd31;
                r.nmon  = 4'd12;
                r.nyear = YEAR_W'(YEAR_MAX);
                r.ovf   = 1'b1;
                return r;
            end
            nm = 1;
            while (nm < 12 && rem >= month_days(ny, nm)) begin
                rem -= month_days(ny, nm);
                nm++;
            end
            r.nday  = DAY_W'(rem + 1);
            r.nmon  = MON_W'(nm);
            r.nyear = YEAR_W'(ny);
            return r;
        endfunction

        function void log_request(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                  logic [YEAR_W-1:0] y, logic [ADD_BITS-1:0] add);
            pending_q.push_back(calc_date(d, m, y, add));
        endfunction

        function void field_diff(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void compare_result(date_res_t act);
            date_res_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %p", $time, act);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            field_diff("date_ok", e.ok, act.ok);
            field_diff("error_code", e.err, act.err);
            field_diff("day_number", e.dnum, act.dnum);
            field_diff("new_day", e.nday, act.nday);
            field_diff("new_month", e.nmon, act.nmon);
            field_diff("new_year", e.nyear, act.nyear);
            field_diff("year_overflow", e.ovf, act.ovf);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [DAY_W-1:0]      date_day;
    logic [MON_W-1:0]      date_month;
    logic [YEAR_W-1:0]     date_year;
    logic [ADD_BITS-1:0]   days_to_add;
    logic                  out_valid;
    logic                  out_ready;
    logic                  date_ok;
    logic [ERR_W-1:0]      error_code;
    logic [DN_W-1:0]       day_number;
    logic [DAY_W-1:0]      new_day;
    logic [MON_W-1:0]      new_month;
    logic [YEAR_W-1:0]     new_year;
    logic                  year_overflow;

    date_scoreboard sb;

    // Idle/stall knobs, percent of cycles; set per phase by the main sequence
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // Raised by the main sequence, taken by the receiver to start a long hold
    bit          hold_req;

    date_validate_number_add_days dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .date_day      (date_day),
        .date_month    (date_month),
        .date_year     (date_year),
        .days_to_add   (days_to_add),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .date_ok       (date_ok),
        .error_code    (error_code),
        .day_number    (day_number),
        .new_day       (new_day),
        .new_month     (new_month),
        .new_year      (new_year),
        .year_overflow (year_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item; optional random idle gap first. Valid is only lowered
    // inside a gap, so back-to-back items keep it high without a glitch.
    // Handshake signals are read right after the edge, i.e. their values at it.
    task automatic send_item(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                             input logic [YEAR_W-1:0] y, input logic [ADD_BITS-1:0] add);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        date_day    <= d;
        date_month  <= m;
        date_year   <= y;
        days_to_add <= add;
        do
            @(posedge clk);
        while (!in_ready);
        sb.log_request(d, m, y, add);
    endtask

    // Random item: mostly valid dates so the year/month walk is exercised,
    // the rest bad days, bad months and unconstrained noise
    task automatic send_random();
        int unsigned      kind, y, m, d, lim;
        logic [ADD_BITS-1:0] add;
        kind = $urandom_range(99);
        // Near the top year the walk can run off the end and saturate
        y = ($urandom_range(7) == 0) ? $urandom_range(16250, YEAR_MAX)
                                     : $urandom_range(FIRST_YEAR, YEAR_MAX);
        m = $urandom_range(1, 12);
        lim = date_scoreboard::month_days(y, m);
        d = $urandom_range(1, lim);
        add = ($urandom_range(3) == 0) ? ADD_BITS'($urandom_range(0, 400))
                                       : ADD_BITS'($urandom);
        if (kind < 70) begin
            send_item(DAY_W'(d), MON_W'(m), YEAR_W'(y), add);
        end
        else if (kind < 80) begin
            // day just out of range, or zero
            d = (lim < 31 && $urandom_range(1)) ? $urandom_range(lim + 1, 31) : 0;
            send_item(DAY_W'(d), MON_W'(m), YEAR_W'(y), add);
        end
        else if (kind < 90) begin
            m = ($urandom_range(1)) ? 0 : $urandom_range(13, 15);
            send_item(DAY_W'($urandom), MON_W'(m), YEAR_W'(y), add);
        end
        else begin
            send_item(DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom),
                      ADD_BITS'($urandom));
        end
    endtask

    // Receiver: checks each accepted result, then picks next cycle's ready.
    // A requested hold keeps ready low for a long stretch, counted here.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.compare_result('{date_ok, error_code, day_number, new_day,
                                    new_month, new_year, year_overflow});
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: cycles with no item moving on either channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("date_validate_number_add_days verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        date_day       = '0;
        date_month     = '0;
        date_year      = '0;
        days_to_add    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: check order, each error kind, leap rules, day-number
        // origin, month and year rollover, and saturation at the top year
        send_item(5'd0,  4'd0,  14'd0,     16'd0);      // year too early, all zero
        send_item(5'd31, 4'd12, 14'd1600,  16'd5);      // last year before range
        send_item(5'd1,  4'd0,  14'd1601,  16'd0);      // month zero
        send_item(5'd1,  4'd13, 14'd1601,  16'd0);
        send_item(5'd31, 4'd15, 14'd1601,  16'hFFFF);
        send_item(5'd0,  4'd1,  14'd1601,  16'd0);      // day zero
        send_item(5'd1,  4'd1,  14'd1601,  16'd0);      // day number origin
        send_item(5'd1,  4'd1,  14'd1601,  16'hFFFF);
        send_item(5'd29, 4'd2,  14'd2000,  16'd0);      // leap by 400 rule
        send_item(5'd29, 4'd2,  14'd1900,  16'd0);      // century, not leap
        send_item(5'd29, 4'd2,  14'd2004,  16'd365);
        send_item(5'd29, 4'd2,  14'd2001,  16'd0);
        send_item(5'd31, 4'd4,  14'd2023,  16'd0);      // 31 in a 30-day month
        send_item(5'd30, 4'd4,  14'd2023,  16'd1);
        send_item(5'd31, 4'd12, 14'd1999,  16'd1);      // year rollover
        send_item(5'd28, 4'd2,  14'd2024,  16'd1);      // into Feb 29
        send_item(5'd28, 4'd2,  14'd2100,  16'd1);      // straight to Mar 1
        send_item(5'd31, 4'd12, 14'd16383, 16'd0);      // top date, no overflow
        send_item(5'd31, 4'd12, 14'd16383, 16'd1);      // one day past the top
        send_item(5'd1,  4'd1,  14'd16383, 16'hFFFF);
        send_item(5'd29, 4'd2,  14'd16383, 16'd0);
        send_item(5'd29, 4'd2,  14'd16000, 16'hFFFF);
        send_item(5'd31, 4'd7,  14'd9999,  16'h5555);
        send_item(5'd31, 4'd3,  14'd1601,  16'hAAAA);
        send_item(5'd15, 4'd6,  14'd16200, 16'hFFFF);   // lands just under the top

        // Random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // Long receiver hold while items keep coming: fills the
                // output register and the walker, so in_ready must drop
                if (phase == 0 && n == 50)
                    hold_req = 1'b1;
                send_random();
            end
        end
        in_valid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("date_validate_number_add_days verification clean");
        else
            $display("date_validate_number_add_days verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/dvnad_pkg.sv
rtl/dvnad_useq.sv
rtl/date_validate_number_add_days.sv
sim/tb_top.sv
